[hdl/swtrm_pkg.sv]
// Shared types and constants for the sliding-window typing rate meter.
// No dependencies; imported by swtrm_cell and sliding_window_typing_rate_meter.
package swtrm_pkg;

  localparam int BUCKET_W       = 16;
  localparam int SECONDS_W      = 32;
  localparam int RATE_W         = 8;
  localparam int BAND_W         = 3;
  localparam int LIMIT_W        = 8;
  localparam int REG_INDEX_W    = 2;
  localparam int S_TDATA_W      = 40;
  localparam int M_TDATA_W      = 16;
  localparam int WINDOW_DEFAULT = 15;
  localparam int WPM_SCALE      = 12;

  localparam logic [RATE_W-1:0] RATE_MAX = 8'd255;

  localparam logic [BAND_W-1:0] BAND_IDLE = 3'd0;
  localparam logic [BAND_W-1:0] BAND_PREP = 3'd1;
  localparam logic [BAND_W-1:0] BAND_SLOW = 3'd2;
  localparam logic [BAND_W-1:0] BAND_MID  = 3'd3;
  localparam logic [BAND_W-1:0] BAND_FAST = 3'd4;
  localparam logic [BAND_W-1:0] BAND_NONE = 3'd5;

  localparam logic [REG_INDEX_W-1:0] REG_IDLE_LIMIT = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PREP_LIMIT = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SLOW_LIMIT = 2'd2;
  localparam logic [REG_INDEX_W-1:0] REG_MID_LIMIT  = 2'd3;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = 8'd10;
  localparam logic [LIMIT_W-1:0] PREP_LIMIT_RST = 8'd20;
  localparam logic [LIMIT_W-1:0] SLOW_LIMIT_RST = 8'd60;
  localparam logic [LIMIT_W-1:0] MID_LIMIT_RST  = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_SUM,
    ST_SCALE,
    ST_DIV,
    ST_FINISH
  } meter_state_t;

endpackage

[hdl/swtrm_cell.sv]
// One bucket of the per-second ring: a count register that takes its
// neighbour's value whenever the ring shifts. Depends on swtrm_pkg.
module swtrm_cell import swtrm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [BUCKET_W-1:0] shift_in,
  output logic [BUCKET_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

[hdl/sliding_window_typing_rate_meter.sv]
// Sliding-window typing rate meter: top level with control sequencer,
// divider and a ring of swtrm_cell buckets. Depends on swtrm_pkg.
//
// Input stream (s_*): s_tuser selects a key event (0) or a once-per-second
// tick (1). s_tdata carries key_down in bit 0 and now_seconds in bits 32:1.
// A key release gives no result. A tick folds elapsed seconds into the
// bucket ring (one second per cycle, at most WINDOW_SECONDS), rotates the
// ring once round to total it, scales and divides by a reciprocal multiply
// and loads the result register; the next item is taken once the sequencer
// is back in idle.
// Output stream (m_*): one transaction per tick with rate, band and change
// flag. A stalled receiver holds the result register; key events are still
// taken meanwhile, and a following tick waits in its last step until the
// register is free.
// Configuration: wr_en/wr_index/wr_data write the four band limits; the user must write them idle only (not enforced).
// Reset (synchronous, rst high) clears the ring, pending count and start
// second, restores the default limits and marks no band seen yet.
module sliding_window_typing_rate_meter import swtrm_pkg::*; #(
  parameter int WINDOW_SECONDS = WINDOW_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,  // key_down[0], now_seconds[32:1], zero pad
  input  logic                   s_tuser,  // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,  // rate_wpm[7:0], band[10:8], band_changed[11]
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [LIMIT_W-1:0]     wr_data
);

  localparam int CNT_W     = $clog2(WINDOW_SECONDS + 1);
  localparam int SUM_W     = $clog2(WINDOW_SECONDS * ((1 << BUCKET_W) - 1) + 1);
  localparam int PROD_W    = SUM_W + 4;
  localparam int SAT_LIMIT = WINDOW_SECONDS << RATE_W;
  localparam int DIV_N     = $clog2(SAT_LIMIT);
  localparam int DIV_L     = $clog2(WINDOW_SECONDS);
  localparam int DIV_S     = DIV_N + DIV_L;
  localparam int RECIP     = ((1 << DIV_S) + WINDOW_SECONDS - 1) / WINDOW_SECONDS;
  localparam int QPROD_W   = DIV_N + DIV_S + 1;

  meter_state_t state, state_next;

  logic [BUCKET_W-1:0]  pending;
  logic [SECONDS_W-1:0] folded_second;
  logic [BAND_W-1:0]    last_band;
  logic [LIMIT_W-1:0]   idle_limit, prep_limit, slow_limit, mid_limit;

  logic [BUCKET_W-1:0]  fold_data;
  logic [CNT_W-1:0]     step_cnt;
  logic [SUM_W-1:0]     acc;
  logic [DIV_N-1:0]     scaled;
  logic [RATE_W-1:0]    quot;
  logic                 sat;

  logic [BUCKET_W-1:0]  bucket [WINDOW_SECONDS];
  logic                 ring_shift;
  logic [BUCKET_W-1:0]  ring_feed;
  logic                 out_load;

  logic                 accept, is_tick, started, advance, wide;
  logic [SECONDS_W-1:0] now, gap;
  logic [PROD_W-1:0]    prod;
  logic [QPROD_W-1:0]   qprod;
  logic [RATE_W-1:0]    rate;
  logic [BAND_W-1:0]    band;

  // ring of buckets; bucket[0] holds the oldest second in the window
  for (genvar k = 0; k < WINDOW_SECONDS; k++) begin : g_cell
    logic [BUCKET_W-1:0] cell_in;
    if (k == WINDOW_SECONDS - 1) begin : g_tail
      assign cell_in = ring_feed;
    end else begin : g_body
      assign cell_in = bucket[k+1];
    end
    swtrm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ring_shift),
      .shift_in (cell_in),
      .value    (bucket[k])
    );
  end

  assign accept  = s_tvalid && s_tready;
  assign is_tick = s_tuser;
  assign now     = s_tdata[SECONDS_W:1];
  assign gap     = now - folded_second;
  assign started = (folded_second != '0);
  assign advance = started && (now > folded_second);
  assign wide    = (gap > SECONDS_W'(WINDOW_SECONDS));
  assign prod    = PROD_W'(acc) * PROD_W'(WPM_SCALE);
  assign qprod   = QPROD_W'(scaled) * QPROD_W'(RECIP);
  assign rate    = sat ? RATE_MAX : quot;

  always_comb begin
    priority if (rate < idle_limit) begin
      band = BAND_IDLE;
    end else if (rate < prep_limit) begin
      band = BAND_PREP;
    end else if (rate < slow_limit) begin
      band = BAND_SLOW;
    end else if (rate < mid_limit) begin
      band = BAND_MID;
    end else begin
      band = BAND_FAST;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && is_tick) begin
          state_next = advance ? ST_FOLD : ST_SUM;
        end
      end
      ST_FOLD: begin
        if (step_cnt == CNT_W'(1)) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (step_cnt == CNT_W'(1)) state_next = ST_SCALE;
      end
      ST_SCALE: state_next = ST_DIV;
      ST_DIV:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    ring_shift = 1'b0;
    ring_feed  = bucket[0];
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_FOLD: begin
        ring_shift = 1'b1;
        ring_feed  = fold_data;
      end
      ST_SUM:    ring_shift = 1'b1;
      ST_SCALE:  ;
      ST_DIV:    ;
      ST_FINISH: out_load = !m_tvalid || m_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending       <= '0;
      folded_second <= '0;
      last_band     <= BAND_NONE;
      idle_limit    <= IDLE_LIMIT_RST;
      prep_limit    <= PREP_LIMIT_RST;
      slow_limit    <= SLOW_LIMIT_RST;
      mid_limit     <= MID_LIMIT_RST;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        unique case (wr_index)
          REG_IDLE_LIMIT: idle_limit <= wr_data;
          REG_PREP_LIMIT: prep_limit <= wr_data;
          REG_SLOW_LIMIT: slow_limit <= wr_data;
          REG_MID_LIMIT:  mid_limit  <= wr_data;
          default: ;
        endcase
      end
      if (accept && !is_tick && !s_tdata[0]) begin
        pending <= pending + 1'b1;
      end
      if (accept && is_tick) begin
        if (!started) begin
          folded_second <= now;
        end else if (advance) begin
          folded_second <= now;
          pending       <= '0;
        end
      end
      if (out_load) begin
        m_tvalid  <= 1'b1;
        last_band <= band;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        fold_data <= wide ? '0 : pending;
        step_cnt  <= (advance && !wide) ? gap[CNT_W-1:0] : CNT_W'(WINDOW_SECONDS);
        acc       <= '0;
      end
      ST_FOLD: begin
        fold_data <= '0;
        step_cnt  <= (step_cnt == CNT_W'(1)) ? CNT_W'(WINDOW_SECONDS) : step_cnt - 1'b1;
      end
      ST_SUM: begin
        acc      <= acc + SUM_W'(bucket[0]);
        step_cnt <= step_cnt - 1'b1;
      end
      ST_SCALE: begin
        sat    <= (prod >= PROD_W'(SAT_LIMIT));
        scaled <= prod[DIV_N-1:0];
      end
      ST_DIV: begin
        quot <= qprod[DIV_S +: RATE_W];
      end
      ST_FINISH: begin
        if (out_load) begin
          m_tdata <= {(M_TDATA_W - RATE_W - BAND_W - 1)'(0), band != last_band, band, rate};
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_fold_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> (step_cnt != '0 && step_cnt <= CNT_W'(WINDOW_SECONDS)))
    else $error("fold step count out of range");

  a_start_second: assert property (@(posedge clk) disable iff (rst)
    (accept && is_tick) |=>
      (folded_second == $past(now) || folded_second == $past(folded_second)))
    else $error("start second moved to an unexpected value");

  a_key_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_tick && !m_tvalid) |=> !m_tvalid)
    else $error("key event produced a result");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[RATE_W+BAND_W-1:RATE_W] <= BAND_FAST))
    else $error("band code out of range");
`endif

endmodule
